/* hw/rtl/nstm_pkg.sv */
// ----------------------------------------------------------------------------
// nstm_pkg: shared types and constants of the nested section timing monitor
// Field widths, status codes, event kinds and controller command bundle.
// ----------------------------------------------------------------------------
package nstm_pkg;

    localparam int unsigned CATEGORIES_DEF  = 8;
    localparam int unsigned WINDOW_DEF      = 1024;
    localparam int unsigned STACK_DEPTH_DEF = 16;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CAT_W   = 3;
    localparam int unsigned TS_W    = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned TOT_W   = 48;
    localparam int unsigned WSUM_W  = 44;

    localparam logic [KIND_W-1:0] KIND_ENTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEAVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request, decode stack
        logic ring_rd;   // issue ring read
        logic update;    // apply record to ring and statistics
        logic div_start; // start the mean divider
        logic out_load;  // move result into output register
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

/* hw/rtl/nstm_if.sv */
// ----------------------------------------------------------------------------
// nstm_req_if / nstm_rsp_if: valid-ready channels of the monitor
// Request carries the event, response carries one category report.
// ----------------------------------------------------------------------------
interface nstm_req_if;
    logic                           valid;
    logic                           ready;
    logic [nstm_pkg::KIND_W-1:0]    kind;
    logic [nstm_pkg::CAT_W-1:0]     category;
    logic [nstm_pkg::TS_W-1:0]      timestamp;
    modport source (output valid, kind, category, timestamp, input ready);
    modport sink   (input valid, kind, category, timestamp, output ready);
endinterface

interface nstm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [nstm_pkg::CAT_W-1:0]     report_category;
    logic [nstm_pkg::STAT_W-1:0]    status;
    logic [nstm_pkg::TS_W-1:0]      duration;
    logic [nstm_pkg::CNT_W-1:0]     samples_taken;
    logic [nstm_pkg::TOT_W-1:0]     total_elapsed;
    logic [nstm_pkg::TS_W-1:0]      mean_time;
    logic [nstm_pkg::CNT_W-1:0]     frame_count;
    modport source (output valid, report_category, status, duration, samples_taken,
                    total_elapsed, mean_time, frame_count, input ready);
    modport sink   (input valid, report_category, status, duration, samples_taken,
                    total_elapsed, mean_time, frame_count, output ready);
endinterface

/* hw/rtl/nested_section_timing_monitor_core.sv */
// ----------------------------------------------------------------------------
// nested_section_timing_monitor_core: nested section timing monitor
// Stack of open sections, per-category sample rings and window means.
// ----------------------------------------------------------------------------
// flow: load, stack read, ring read, update, then the bit-serial mean divider,
//   before the result moves into the output register
// requests: one at a time; the next request is taken while the previous result
//   waits in the output register
// reset: synchronous, active low; clears counters, sums, frame count and stack
//   level; stack and ring contents stay undefined until written
module nested_section_timing_monitor_core #(
    parameter int unsigned CATEGORIES  = nstm_pkg::CATEGORIES_DEF,
    parameter int unsigned WINDOW      = nstm_pkg::WINDOW_DEF,
    parameter int unsigned STACK_DEPTH = nstm_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nstm_req_if.sink   req,
    nstm_rsp_if.source rsp
);
    nstm_pkg::t_cmd w_cmd;
    nstm_pkg::t_sts w_sts;

    nstm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req.valid),
        .o_req_ready (req.ready),
        .i_out_busy  (rsp.valid && !rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    nstm_datapath #(
        .CATEGORIES  (CATEGORIES),
        .WINDOW      (WINDOW),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_kind      (req.kind),
        .i_category  (req.category),
        .i_timestamp (req.timestamp),
        .rsp         (rsp)
    );
endmodule

/* hw/rtl/nstm_ram.sv */
// ----------------------------------------------------------------------------
// nstm_ram: generic single-port ram with registered read
// One access per cycle; a write also returns the old word on the read port.
// ----------------------------------------------------------------------------
module nstm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* hw/rtl/nstm_div.sv */
// ----------------------------------------------------------------------------
// nstm_div: restoring divider, one quotient bit per cycle
// Divides the window sum by the sample divisor; quotient truncated to 32 bits.
// ----------------------------------------------------------------------------
module nstm_div #(
    parameter int unsigned NUM_W = 44,
    parameter int unsigned DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_q     = r_q;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = CW'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_busy && (r_cnt == CW'(1));
    // zero divisor gives all ones; caller masks that case
    assign o_quot = n_q[31:0];
endmodule

/* hw/rtl/nstm_datapath.sv */
// ----------------------------------------------------------------------------
// nstm_datapath: section stack, sample ring, per-category statistics
// Executes controller commands and holds the output register.
// ----------------------------------------------------------------------------
module nstm_datapath #(
    parameter int unsigned CATEGORIES  = nstm_pkg::CATEGORIES_DEF,
    parameter int unsigned WINDOW      = nstm_pkg::WINDOW_DEF,
    parameter int unsigned STACK_DEPTH = nstm_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nstm_pkg::t_cmd              i_cmd,
    output nstm_pkg::t_sts              o_sts,
    input  logic [nstm_pkg::KIND_W-1:0] i_kind,
    input  logic [nstm_pkg::CAT_W-1:0]  i_category,
    input  logic [nstm_pkg::TS_W-1:0]   i_timestamp,
    nstm_rsp_if.source                  rsp
);
    localparam int unsigned CI_W  = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam int unsigned WI_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SI_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned LV_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned DEN_W = $clog2(WINDOW + 1);
    localparam int unsigned RING_D = CATEGORIES * WINDOW;
    localparam int unsigned RA_W   = (RING_D > 1) ? $clog2(RING_D) : 1;
    localparam int unsigned SE_W   = nstm_pkg::CAT_W + nstm_pkg::TS_W;
    localparam logic [nstm_pkg::CNT_W-1:0] CNT_MAX = '1;
    localparam logic [nstm_pkg::TOT_W-1:0] TOT_MAX = '1;

    logic [LV_W-1:0]                 r_level;
    logic [nstm_pkg::CNT_W-1:0]      r_count [CATEGORIES];
    logic [WI_W-1:0]                 r_slot  [CATEGORIES];
    logic [nstm_pkg::WSUM_W-1:0]     r_wsum  [CATEGORIES];
    logic [nstm_pkg::TOT_W-1:0]      r_total [CATEGORIES];
    logic [nstm_pkg::CNT_W-1:0]      r_frames;

    logic [CI_W-1:0]                 r_cat;
    logic [nstm_pkg::TS_W-1:0]       r_ts;
    logic [nstm_pkg::STAT_W-1:0]     r_status;
    logic                            r_rec;
    logic [nstm_pkg::TS_W-1:0]       r_dur;
    logic [nstm_pkg::TS_W-1:0]       r_mean;
    logic                            r_vld;

    logic                            w_st_we;
    logic [SI_W-1:0]                 w_st_addr;
    logic [SE_W-1:0]                 w_st_rd;
    logic                            w_rg_we;
    logic [RA_W-1:0]                 w_rg_addr;
    logic [nstm_pkg::TS_W-1:0]       w_rg_rd;
    logic [CI_W-1:0]                 w_in_cat;
    logic [CI_W-1:0]                 w_cat;
    logic [nstm_pkg::CNT_W-1:0]      w_n;
    logic [WI_W-1:0]                 w_slot;
    logic [nstm_pkg::TOT_W:0]        w_tsum;
    logic [DEN_W-1:0]                w_den;
    logic                            w_div_done;
    logic [31:0]                     w_quot;

    // category reduced modulo the category count through a small constant table
    always_comb begin
        w_in_cat = '0;
        for (int i = 0; i < (1 << nstm_pkg::CAT_W); i++) begin
            if (i_category == nstm_pkg::CAT_W'(i)) begin
                w_in_cat = CI_W'(i % CATEGORIES);
            end
        end
    end

    // stack: push writes at level, pop reads at level-1
    assign w_st_we   = i_cmd.load && (i_kind == nstm_pkg::KIND_ENTER)
                       && (r_level < LV_W'(STACK_DEPTH));
    assign w_st_addr = (i_kind == nstm_pkg::KIND_ENTER) ? SI_W'(r_level)
                                                        : SI_W'(r_level - 1'b1);

    nstm_ram #(.WIDTH(SE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_addr  (w_st_addr),
        .i_wdata ({nstm_pkg::CAT_W'(w_in_cat), i_timestamp}),
        .o_rdata (w_st_rd)
    );

    // stack read is valid only in the ring_rd cycle; later the frozen category
    assign w_cat  = (i_cmd.ring_rd && r_rec) ? CI_W'(w_st_rd[SE_W-1 -: nstm_pkg::CAT_W])
                                             : r_cat;
    assign w_n    = r_count[w_cat];
    assign w_slot = r_slot[w_cat];

    assign w_rg_we   = i_cmd.update && r_rec;
    assign w_rg_addr = RA_W'(w_cat) * RA_W'(WINDOW) + RA_W'(w_slot);

    nstm_ram #(.WIDTH(nstm_pkg::TS_W), .DEPTH(RING_D)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_rg_we),
        .i_addr  (w_rg_addr),
        .i_wdata (r_dur),
        .o_rdata (w_rg_rd)
    );

    assign w_tsum = {1'b0, r_total[w_cat]} + (nstm_pkg::TOT_W + 1)'(r_dur);
    assign w_den  = (w_n < nstm_pkg::CNT_W'(WINDOW)) ? DEN_W'(w_n) : DEN_W'(WINDOW);

    nstm_div #(.NUM_W(nstm_pkg::WSUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_wsum[w_cat]),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );
    assign o_sts.div_done = w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_frames <= '0;
            r_vld    <= 1'b0;
            r_rec    <= 1'b0;
            for (int i = 0; i < CATEGORIES; i++) begin
                r_count[i] <= '0;
                r_slot[i]  <= '0;
                r_wsum[i]  <= '0;
                r_total[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_cat    <= w_in_cat;
                r_ts     <= i_timestamp;
                r_rec    <= 1'b0;
                r_status <= nstm_pkg::STAT_OK;
                case (i_kind)
                    nstm_pkg::KIND_ENTER: begin
                        if (r_level < LV_W'(STACK_DEPTH)) begin
                            r_level <= r_level + 1'b1;
                        end else begin
                            r_status <= nstm_pkg::STAT_OVERFLOW;
                        end
                    end
                    nstm_pkg::KIND_LEAVE: begin
                        if (r_level == '0) begin
                            r_status <= nstm_pkg::STAT_UNDERFLOW;
                        end else begin
                            r_level <= r_level - 1'b1;
                            r_rec   <= 1'b1;
                        end
                    end
                    nstm_pkg::KIND_FRAME: r_frames <= r_frames + 1'b1;
                    default: begin
                        r_frames <= '0;
                        for (int i = 0; i < CATEGORIES; i++) begin
                            r_count[i] <= '0;
                            r_slot[i]  <= '0;
                            r_wsum[i]  <= '0;
                            r_total[i] <= '0;
                        end
                    end
                endcase
            end
            if (i_cmd.ring_rd) begin
                // stack data valid now: freeze category and duration
                r_cat <= w_cat;
                r_dur <= r_rec ? (r_ts - w_st_rd[nstm_pkg::TS_W-1:0]) : '0;
                r_rec <= r_rec;
            end
            if (i_cmd.update && r_rec) begin
                r_wsum[r_cat] <= r_wsum[r_cat] + nstm_pkg::WSUM_W'(r_dur)
                    - ((w_n >= nstm_pkg::CNT_W'(WINDOW)) ?
                       nstm_pkg::WSUM_W'(w_rg_rd) : '0);
                // slot tracks count mod window and sticks once the count saturates
                if (w_n != CNT_MAX) begin
                    r_count[r_cat] <= w_n + 1'b1;
                    r_slot[r_cat]  <= (w_slot == WI_W'(WINDOW - 1)) ? '0
                                                                    : w_slot + 1'b1;
                end
                r_total[r_cat] <= w_tsum[nstm_pkg::TOT_W] ? TOT_MAX
                                                           : w_tsum[nstm_pkg::TOT_W-1:0];
                r_rec <= 1'b0;
            end
            if (w_div_done) begin
                r_mean <= (w_den == '0) ? '0 : w_quot;
            end
            if (i_cmd.out_load) begin
                r_vld <= 1'b1;
            end else if (rsp.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            rsp.report_category <= nstm_pkg::CAT_W'(w_cat);
            rsp.status          <= r_status;
            rsp.duration        <= r_dur;
            rsp.samples_taken   <= w_n;
            rsp.total_elapsed   <= r_total[w_cat];
            rsp.mean_time       <= r_mean;
            rsp.frame_count     <= r_frames;
        end
    end
    assign rsp.valid = r_vld;
endmodule

/* hw/rtl/nstm_ctrl.sv */
// ----------------------------------------------------------------------------
// nstm_ctrl: sequencer of one event
// Load, stack read, ring read, update, divide, then hand off the result.
// ----------------------------------------------------------------------------
module nstm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  logic           i_out_busy,
    output nstm_pkg::t_cmd o_cmd,
    input  nstm_pkg::t_sts i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STK  = 3'd1;
    localparam logic [2:0] S_RING = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: if (i_req_valid) begin
                o_cmd.load = 1'b1;
                n_state    = S_STK;
            end
            S_STK: begin
                o_cmd.ring_rd = 1'b1;
                n_state       = S_RING;
            end
            S_RING: n_state = S_UPD;
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: if (i_sts.div_done) begin
                n_state = S_OUT;
            end
            S_OUT: if (!i_out_busy) begin
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* tb/nstm_report_checker.sv */
// ----------------------------------------------------------------------------
// nstm_report_checker: report predictor and comparator for the timing monitor
// Watches the request and report channels, keeps its own copy of the section
// stack and the per-category statistics, and compares every report in order.
// ----------------------------------------------------------------------------
module nstm_report_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    nstm_req_if  req,
    nstm_rsp_if  rsp,
    output int   o_errors,
    output int   o_pending
);
    import nstm_pkg::*;

    localparam int unsigned NCAT  = CATEGORIES_DEF;
    localparam int unsigned WIN   = WINDOW_DEF;
    localparam int unsigned DEPTH = STACK_DEPTH_DEF;
    localparam logic [TOT_W-1:0] TOTAL_SAT = '1;
    localparam logic [CNT_W-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic [CAT_W-1:0]  category;
        logic [STAT_W-1:0] status;
        logic [TS_W-1:0]   duration;
        logic [CNT_W-1:0]  samples;
        logic [TOT_W-1:0]  total;
        logic [TS_W-1:0]   mean;
        logic [CNT_W-1:0]  frames;
    } t_report;

    logic [CAT_W-1:0]  open_cat [DEPTH];
    logic [TS_W-1:0]   open_ts  [DEPTH];
    int unsigned       open_level;
    logic [TS_W-1:0]   ring     [NCAT][WIN];
    logic [CNT_W-1:0]  cnt      [NCAT];
    logic [WSUM_W-1:0] wsum     [NCAT];
    logic [TOT_W-1:0]  total    [NCAT];
    logic [CNT_W-1:0]  frame_cnt;

    t_report expected_reports[$];

    function automatic t_report category_report(logic [CAT_W-1:0] c, logic [STAT_W-1:0] st,
                                                 logic [TS_W-1:0] dur);
        t_report r;
        logic [CNT_W-1:0] div;
        div = (cnt[c] < WIN) ? cnt[c] : CNT_W'(WIN);
        r.category = c;
        r.status   = st;
        r.duration = dur;
        r.samples  = cnt[c];
        r.total    = total[c];
        r.mean     = (div != 0) ? TS_W'(wsum[c] / div) : '0;
        r.frames   = frame_cnt;
        return r;
    endfunction

    function automatic void record_section(logic [CAT_W-1:0] c, logic [TS_W-1:0] dur);
        int unsigned slot;
        logic [TOT_W:0] sum;
        slot = cnt[c] % WIN;
        if (cnt[c] >= WIN) wsum[c] = wsum[c] - ring[c][slot];
        ring[c][slot] = dur;
        wsum[c] = wsum[c] + dur;
        if (cnt[c] != COUNT_SAT) cnt[c] = cnt[c] + 1;
        sum = {1'b0, total[c]} + dur;
        total[c] = (sum > TOTAL_SAT) ? TOTAL_SAT : sum[TOT_W-1:0];
    endfunction

    function automatic t_report predict_report(logic [KIND_W-1:0] k, logic [CAT_W-1:0] c,
                                               logic [TS_W-1:0] ts);
        logic [CAT_W-1:0] pc;
        logic [TS_W-1:0] dur;
        c = CAT_W'(c % NCAT);
        case (k)
            KIND_ENTER: begin
                if (open_level >= DEPTH) return category_report(c, STAT_OVERFLOW, '0);
                open_cat[open_level] = c;
                open_ts[open_level]  = ts;
                open_level++;
                return category_report(c, STAT_OK, '0);
            end
            KIND_LEAVE: begin
                if (open_level == 0) return category_report(c, STAT_UNDERFLOW, '0);
                open_level--;
                pc  = open_cat[open_level];
                dur = ts - open_ts[open_level];
                record_section(pc, dur);
                return category_report(pc, STAT_OK, dur);
            end
            KIND_FRAME: begin
                frame_cnt = frame_cnt + 1;
                return category_report(c, STAT_OK, '0);
            end
            default: begin
                for (int i = 0; i < NCAT; i++) begin
                    cnt[i]   = '0;
                    wsum[i]  = '0;
                    total[i] = '0;
                end
                frame_cnt = '0;
                return category_report(c, STAT_OK, '0);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [TOT_W-1:0] exp_v,
                                        logic [TOT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            o_errors++;
        end
    endfunction

    initial begin
        o_errors   = 0;
        open_level = 0;
        frame_cnt  = '0;
        for (int i = 0; i < NCAT; i++) begin
            cnt[i]   = '0;
            wsum[i]  = '0;
            total[i] = '0;
        end
    end

    assign o_pending = expected_reports.size();

    always @(posedge i_clk) begin
        t_report e;
        if (i_rst_n) begin
            // report first: it belongs to an earlier request
            if (rsp.valid && rsp.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report with no request waiting");
                    o_errors++;
                end else begin
                    e = expected_reports.pop_front();
                    check_field("report_category", e.category, rsp.report_category);
                    check_field("status", e.status, rsp.status);
                    check_field("duration", e.duration, rsp.duration);
                    check_field("samples_taken", e.samples, rsp.samples_taken);
                    check_field("total_elapsed", e.total, rsp.total_elapsed);
                    check_field("mean_time", e.mean, rsp.mean_time);
                    check_field("frame_count", e.frames, rsp.frame_count);
                end
            end
            if (req.valid && req.ready)
                expected_reports.push_back(predict_report(req.kind, req.category, req.timestamp));
        end
    end
endmodule

/* tb/tb_nested_section_timing_monitor_core.sv */
// ----------------------------------------------------------------------------
// tb_nested_section_timing_monitor_core: testbench of the section timing monitor
// Directed stack underflow/overflow and wrap cases, a long single-category run,
// then random nested sections with stalls.
// ----------------------------------------------------------------------------
module tb_nested_section_timing_monitor_core;
    import nstm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   hold_req = 1'b0;
    int   level = 0;
    logic [TS_W-1:0] now = '0;

    nstm_req_if req_ch ();
    nstm_rsp_if rsp_ch ();

    nested_section_timing_monitor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    nstm_report_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_nested_section_timing_monitor_core NOT OK");
            $finish;
        end
    end

    // report side: random stall per report, one long hold-off on request
    initial begin
        int gap;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = hold_req ? 400 : $urandom_range(0, 4);
            hold_req = 1'b0;
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    task automatic send(logic [KIND_W-1:0] k, logic [CAT_W-1:0] c, logic [TS_W-1:0] ts);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= k;
        req_ch.category  <= c;
        req_ch.timestamp <= ts;
        do @(posedge i_clk); while (!req_ch.ready);
        if (k == KIND_ENTER && level < STACK_DEPTH_DEF) level++;
        if (k == KIND_LEAVE && level > 0) level--;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int r;
        logic [CAT_W-1:0] c;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_ENTER;
        req_ch.category  <= '0;
        req_ch.timestamp <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: underflow, timestamp wrap, full stack, clear
        send(KIND_LEAVE, 3'd7, '0);
        send(KIND_FRAME, 3'd0, '1);
        send(KIND_ENTER, 3'd0, 32'hFFFF_FFFF);
        send(KIND_LEAVE, 3'd5, 32'd5);
        for (int i = 0; i < STACK_DEPTH_DEF; i++)
            send(KIND_ENTER, CAT_W'(i), 32'(i * 32'h1111_1111));
        send(KIND_ENTER, 3'd6, 32'h1234_5678);
        for (int i = 0; i < STACK_DEPTH_DEF; i++)
            send(KIND_LEAVE, 3'd1, ~32'(i));
        send(KIND_CLEAR, 3'd5, '0);
        send(KIND_LEAVE, 3'd2, '1);

        // sender waits for every report before the window run
        drain();

        // one category with many sections in a row
        send(KIND_CLEAR, 3'd3, '0);
        for (int i = 0; i < 300; i++) begin
            now = now + $urandom_range(0, 255);
            send(KIND_ENTER, 3'd3, now);
            now = now + $urandom_range(0, 65535);
            send(KIND_LEAVE, CAT_W'($urandom_range(0, 7)), now);
        end

        // random nested sections, with a long report stall early on
        hold_req = 1'b1;
        for (int i = 0; i < 560; i++) begin
            r = $urandom_range(0, 99);
            c = CAT_W'($urandom_range(0, 7));
            now = now + $urandom;
            if (r < 3)
                send(KIND_CLEAR, c, $urandom);
            else if (r < 8)
                send(KIND_FRAME, c, now);
            else if (r < 12)
                send(KIND_W'($urandom_range(0, 1)), c, $urandom);
            else if (level == 0 || (r < 55 && level < STACK_DEPTH_DEF) || r > 97)
                send(KIND_ENTER, c, now);
            else
                send(KIND_LEAVE, c, now);
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_nested_section_timing_monitor_core OK");
        else
            $display("tb_nested_section_timing_monitor_core NOT OK");
        $finish;
    end
endmodule
